[design/yuv420_block_to_rgba_defines.svh]
// Assertion macros for the 4:2:0 block to RGBA converter
`ifndef YUV420_BLOCK_TO_RGBA_DEFINES_SVH
`define YUV420_BLOCK_TO_RGBA_DEFINES_SVH

// same-cycle implication, checked out of reset
`define Y2R_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define Y2R_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/yuv2rgb_pkg.sv]
// Types and constants shared by the 4:2:0 block to RGBA converter
`default_nettype none
package yuv2rgb_pkg;

  localparam int unsigned COEF_W  = 16;
  localparam int unsigned SHIFT_W = 4;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned PIX_W   = 32;

  // register indexes
  localparam logic [IDX_W-1:0] REG_CR_TO_RED    = 3'd0;
  localparam logic [IDX_W-1:0] REG_CR_TO_GREEN  = 3'd1;
  localparam logic [IDX_W-1:0] REG_CB_TO_GREEN  = 3'd2;
  localparam logic [IDX_W-1:0] REG_CB_TO_BLUE   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROUND_OFFSET = 3'd4;
  localparam logic [IDX_W-1:0] REG_FRAC_SHIFT   = 3'd5;

  // BT.601 reset values
  localparam logic signed [COEF_W-1:0] RST_CR_TO_RED   = 16'sd22987;
  localparam logic signed [COEF_W-1:0] RST_CR_TO_GREEN = -16'sd11698;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_GREEN = -16'sd5636;
  localparam logic signed [COEF_W-1:0] RST_CB_TO_BLUE  = 16'sd29049;
  localparam logic [COEF_W-1:0]        RST_ROUND_OFF   = 16'd8192;
  localparam logic [SHIFT_W-1:0]       RST_FRAC_SHIFT  = 4'd14;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic signed [COEF_W-1:0] cr_to_red;
    logic signed [COEF_W-1:0] cr_to_green;
    logic signed [COEF_W-1:0] cb_to_green;
    logic signed [COEF_W-1:0] cb_to_blue;
    logic [COEF_W-1:0]        round_offset;
    logic [SHIFT_W-1:0]       frac_shift;
  } coef_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } blk_t;

  typedef struct packed {
    logic [PIX_W-1:0] top_left;
    logic [PIX_W-1:0] top_right;
    logic [PIX_W-1:0] bottom_left;
    logic [PIX_W-1:0] bottom_right;
  } pix_t;

endpackage
`default_nettype wire

[design/yuv420_block_to_rgba.sv]
// Top level: 4:2:0 2x2 block to four RGBA pixels, with register port
// A taken block passes through one input register and one result register around the matrix logic.
// Throughput: one block per cycle; busy stays low, start may be held high.
// Reset (rst_n low, synchronous): strobes clear, configuration registers return to BT.601.
// The receiver cannot stall the result strobe.
`default_nettype none
`include "yuv420_block_to_rgba_defines.svh"
module yuv420_block_to_rgba (
  input  wire        clk,
  input  wire        rst_n,

  input  wire        start,
  output logic       busy,
  input  wire  [7:0] in_luma_top_left,
  input  wire  [7:0] in_luma_top_right,
  input  wire  [7:0] in_luma_bottom_left,
  input  wire  [7:0] in_luma_bottom_right,
  input  wire  [7:0] in_chroma_blue,
  input  wire  [7:0] in_chroma_red,

  output logic        out_valid,
  output logic [31:0] out_pixel_top_left,
  output logic [31:0] out_pixel_top_right,
  output logic [31:0] out_pixel_bottom_left,
  output logic [31:0] out_pixel_bottom_right,

  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  yuv2rgb_pkg::coef_t coef_r;
  yuv2rgb_pkg::blk_t  stg_blk_r;
  logic               stg_vld_r;
  yuv2rgb_pkg::pix_t  pix_nxt;
  yuv2rgb_pkg::pix_t  pix_r;
  logic               out_vld_r;
  logic               in_acc;
  logic               alpha_ok;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_acc    = start && !busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.cr_to_red    <= yuv2rgb_pkg::RST_CR_TO_RED;
      coef_r.cr_to_green  <= yuv2rgb_pkg::RST_CR_TO_GREEN;
      coef_r.cb_to_green  <= yuv2rgb_pkg::RST_CB_TO_GREEN;
      coef_r.cb_to_blue   <= yuv2rgb_pkg::RST_CB_TO_BLUE;
      coef_r.round_offset <= yuv2rgb_pkg::RST_ROUND_OFF;
      coef_r.frac_shift   <= yuv2rgb_pkg::RST_FRAC_SHIFT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        yuv2rgb_pkg::REG_CR_TO_RED:    coef_r.cr_to_red    <= signed'(cfg_data);
        yuv2rgb_pkg::REG_CR_TO_GREEN:  coef_r.cr_to_green  <= signed'(cfg_data);
        yuv2rgb_pkg::REG_CB_TO_GREEN:  coef_r.cb_to_green  <= signed'(cfg_data);
        yuv2rgb_pkg::REG_CB_TO_BLUE:   coef_r.cb_to_blue   <= signed'(cfg_data);
        yuv2rgb_pkg::REG_ROUND_OFFSET: coef_r.round_offset <= cfg_data;
        yuv2rgb_pkg::REG_FRAC_SHIFT:   coef_r.frac_shift   <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else begin
      stg_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      stg_blk_r.luma_top_left     <= in_luma_top_left;
      stg_blk_r.luma_top_right    <= in_luma_top_right;
      stg_blk_r.luma_bottom_left  <= in_luma_bottom_left;
      stg_blk_r.luma_bottom_right <= in_luma_bottom_right;
      stg_blk_r.chroma_blue       <= in_chroma_blue;
      stg_blk_r.chroma_red        <= in_chroma_red;
    end
  end

  yuv2rgb_core u_core (
    .blk  (stg_blk_r),
    .coef (coef_r),
    .pix  (pix_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= stg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (stg_vld_r) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_pixel_top_left     = pix_r.top_left;
  assign out_pixel_top_right    = pix_r.top_right;
  assign out_pixel_bottom_left  = pix_r.bottom_left;
  assign out_pixel_bottom_right = pix_r.bottom_right;

  assign alpha_ok = (out_pixel_top_left[31:24] == yuv2rgb_pkg::ALPHA_OPAQUE) &&
                    (out_pixel_top_right[31:24] == yuv2rgb_pkg::ALPHA_OPAQUE) &&
                    (out_pixel_bottom_left[31:24] == yuv2rgb_pkg::ALPHA_OPAQUE) &&
                    (out_pixel_bottom_right[31:24] == yuv2rgb_pkg::ALPHA_OPAQUE);

  `Y2R_ASSERT_NEXT(a_stage_to_out, stg_vld_r, out_valid, "staged item lost")
  `Y2R_ASSERT_NEXT(a_no_phantom, !stg_vld_r, !out_valid, "result without item")
  `Y2R_ASSERT_NEXT(a_accept_stage, in_acc, stg_vld_r, "accepted item not staged")
  `Y2R_ASSERT_NOW(a_alpha, out_valid, alpha_ok, "alpha not opaque")

endmodule
`default_nettype wire

[design/yuv2rgb_core.sv]
// Colour matrix, rounding shift, clamp and RGBA packing for one 2x2 block
`default_nettype none
module yuv2rgb_core (
  input  wire yuv2rgb_pkg::blk_t  blk,
  input  wire yuv2rgb_pkg::coef_t coef,
  output yuv2rgb_pkg::pix_t       pix
);

  // products are 25 bits; green sums two plus offset, fits in 26
  localparam int unsigned PROD_W = 25;
  localparam int unsigned SUM_W  = 26;
  localparam int unsigned VAL_W  = SUM_W + 1;

  logic signed [8:0]        cb_c;
  logic signed [8:0]        cr_c;
  logic signed [PROD_W-1:0] p_rr;
  logic signed [PROD_W-1:0] p_rg;
  logic signed [PROD_W-1:0] p_bg;
  logic signed [PROD_W-1:0] p_bb;
  logic signed [SUM_W-1:0]  off_s;
  logic signed [SUM_W-1:0]  s_red;
  logic signed [SUM_W-1:0]  s_grn;
  logic signed [SUM_W-1:0]  s_blu;
  logic signed [SUM_W-1:0]  d_red;
  logic signed [SUM_W-1:0]  d_grn;
  logic signed [SUM_W-1:0]  d_blu;
  logic [7:0]               luma [4];
  logic [yuv2rgb_pkg::PIX_W-1:0] word [4];

  function automatic logic [7:0] clamp8(input logic signed [VAL_W-1:0] v);
    logic [7:0] r;
    if (v < 0) begin
      r = 8'd0;
    end else if (v > VAL_W'(255)) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  assign cb_c  = signed'({1'b0, blk.chroma_blue} - 9'd128);
  assign cr_c  = signed'({1'b0, blk.chroma_red} - 9'd128);

  assign p_rr  = cr_c * coef.cr_to_red;
  assign p_rg  = cr_c * coef.cr_to_green;
  assign p_bg  = cb_c * coef.cb_to_green;
  assign p_bb  = cb_c * coef.cb_to_blue;

  assign off_s = signed'(SUM_W'(coef.round_offset));
  assign s_red = SUM_W'(p_rr) + off_s;
  assign s_grn = SUM_W'(p_bg) + SUM_W'(p_rg) + off_s;
  assign s_blu = SUM_W'(p_bb) + off_s;

  // arithmetic shift: floor for negative sums
  assign d_red = s_red >>> coef.frac_shift;
  assign d_grn = s_grn >>> coef.frac_shift;
  assign d_blu = s_blu >>> coef.frac_shift;

  assign luma[0] = blk.luma_top_left;
  assign luma[1] = blk.luma_top_right;
  assign luma[2] = blk.luma_bottom_left;
  assign luma[3] = blk.luma_bottom_right;

  for (genvar i = 0; i < 4; i++) begin : g_pix
    logic signed [VAL_W-1:0] y_s;
    assign y_s = signed'(VAL_W'(luma[i]));
    assign word[i] = {yuv2rgb_pkg::ALPHA_OPAQUE,
                      clamp8(y_s + VAL_W'(d_blu)),
                      clamp8(y_s + VAL_W'(d_grn)),
                      clamp8(y_s + VAL_W'(d_red))};
  end

  assign pix.top_left     = word[0];
  assign pix.top_right    = word[1];
  assign pix.bottom_left  = word[2];
  assign pix.bottom_right = word[3];

endmodule
`default_nettype wire
